[hdl/mie_pkg.sv]
`timescale 1ns / 1ps

package mie_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FIXNEG,
        ST_FIXBIG,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic fix_neg;
        logic res_coef;
        logic res_fail;
        logic res_zero;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic mod_one;
        logic run_zero;
        logic run_gt_one;
        logic rem_zero;
    } dp_stat_t;

endpackage

[hdl/mie_datapath.sv]
`timescale 1ns / 1ps

module mie_datapath #(
    parameter int VALUE_WIDTH = mie_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic [VALUE_WIDTH-1:0] cfg_data,
    input  logic [VALUE_WIDTH-1:0] operand,
    input  mie_pkg::dp_cmd_t       cmd,
    output mie_pkg::dp_stat_t      stat,
    output logic [VALUE_WIDTH-1:0] inverse,
    output logic                   status
);
    import mie_pkg::*;

    localparam int CW = VALUE_WIDTH + 2;

    logic [VALUE_WIDTH-1:0] modulus_reg;
    logic [VALUE_WIDTH-1:0] run_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] dvd_reg;
    logic [VALUE_WIDTH-1:0] part_reg;
    logic [CW-1:0]          ccur_reg;
    logic [CW-1:0]          cprev_reg;
    logic [CW-1:0]          prod_reg;
    logic [VALUE_WIDTH-1:0] res_inv_reg;
    logic                   res_stat_reg;
    logic [VALUE_WIDTH-1:0] inverse_reg;
    logic                   status_reg;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   trial_diff;
    logic                   trial_ge;
    logic [CW-1:0]          mod_ext;
    logic                   ccur_ge_mod;
    logic [CW-1:0]          ccur_less_mod;

    assign trial         = {part_reg, dvd_reg[VALUE_WIDTH-1]};
    assign trial_diff    = trial - {1'b0, rem_reg};
    assign trial_ge      = (trial >= {1'b0, rem_reg});
    assign mod_ext       = {2'b00, modulus_reg};
    assign ccur_ge_mod   = (ccur_reg >= mod_ext);
    assign ccur_less_mod = ccur_reg - mod_ext;

    assign stat.mod_zero   = (modulus_reg == '0);
    assign stat.mod_one    = (modulus_reg == VALUE_WIDTH'(1));
    assign stat.run_zero   = (run_reg == '0);
    assign stat.run_gt_one = (run_reg > VALUE_WIDTH'(1));
    assign stat.rem_zero   = (rem_reg == '0);

    assign inverse = inverse_reg;
    assign status  = status_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            modulus_reg <= VALUE_WIDTH'(1);
        end
        else if (cfg_wr) begin
            modulus_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            run_reg   <= operand;
            rem_reg   <= modulus_reg;
            ccur_reg  <= CW'(1);
            cprev_reg <= '0;
        end
        else if (cmd.update) begin
            run_reg   <= rem_reg;
            rem_reg   <= part_reg;
            ccur_reg  <= cprev_reg;
            cprev_reg <= ccur_reg - prod_reg;
        end
        else if (cmd.fix_neg && ccur_reg[CW-1]) begin
            ccur_reg <= ccur_reg + mod_ext;
        end

        if (cmd.div_init) begin
            dvd_reg  <= run_reg;
            part_reg <= '0;
            prod_reg <= '0;
        end
        else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            part_reg <= trial_ge ? trial_diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            prod_reg <= {prod_reg[CW-2:0], 1'b0} + (trial_ge ? cprev_reg : '0);
        end

        if (cmd.res_coef) begin
            res_inv_reg  <= ccur_ge_mod ? ccur_less_mod[VALUE_WIDTH-1:0]
                                        : ccur_reg[VALUE_WIDTH-1:0];
            res_stat_reg <= 1'b0;
        end
        else if (cmd.res_fail) begin
            res_inv_reg  <= '0;
            res_stat_reg <= 1'b1;
        end
        else if (cmd.res_zero) begin
            res_inv_reg  <= '0;
            res_stat_reg <= 1'b0;
        end

        if (cmd.out_load) begin
            inverse_reg <= res_inv_reg;
            status_reg  <= res_stat_reg;
        end
    end

endmodule

[hdl/mie_controller.sv]
`timescale 1ns / 1ps

module mie_controller #(
    parameter int VALUE_WIDTH = mie_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mie_pkg::dp_stat_t stat,
    output mie_pkg::dp_cmd_t  cmd
);
    import mie_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (stat.mod_zero || stat.mod_one || stat.run_zero) begin
                    state_next = ST_WRITE;
                end
                else if (stat.run_gt_one) begin
                    state_next = stat.rem_zero ? ST_WRITE : ST_DIV;
                end
                else begin
                    state_next = ST_FIXNEG;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_CHECK;
            ST_FIXNEG: state_next = ST_FIXBIG;
            ST_FIXBIG: state_next = ST_WRITE;
            ST_WRITE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_valid;
            end
            ST_CHECK: begin
                priority if (stat.mod_zero) begin
                    cmd.res_fail = 1'b1;
                end
                else if (stat.mod_one) begin
                    cmd.res_zero = 1'b1;
                end
                else if (stat.run_zero) begin
                    cmd.res_fail = 1'b1;
                end
                else if (stat.run_gt_one) begin
                    if (stat.rem_zero) begin
                        cmd.res_fail = 1'b1;
                    end
                    else begin
                        cmd.div_init = 1'b1;
                        cnt_next     = CNT_W'(VALUE_WIDTH - 1);
                    end
                end
                else begin
                    cmd = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
            end
            ST_UPDATE: cmd.update   = 1'b1;
            ST_FIXNEG: cmd.fix_neg  = 1'b1;
            ST_FIXBIG: cmd.res_coef = 1'b1;
            ST_WRITE: begin
                if (slot_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

[hdl/modular_inverse_euclid_top.sv]
`timescale 1ns / 1ps

// Channel   Signals                          Item
// in        in_valid, in_ready, operand      one value to invert
// out       out_valid, out_ready, inverse,   inverse and no-inverse flag
//           status
// cfg       cfg_valid, cfg_ready, modulus    modulus write, always ready
//
// An item runs one Euclid step per pass through CHECK, DIV and UPDATE, using the
// bit-serial divider, plus setup, correction (FIXNEG, FIXBIG) and output (WRITE).
// One item is in work at a time.
// Reset clears the controller and sets the modulus to one.
// A result waits in the output register while the next item is accepted.

module modular_inverse_euclid_top #(
    parameter int VALUE_WIDTH = mie_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [VALUE_WIDTH-1:0] modulus,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] operand,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] inverse,
    output logic                   status
);
    import mie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mie_controller #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mie_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_valid & cfg_ready),
        .cfg_data(modulus),
        .operand (operand),
        .cmd     (cmd),
        .stat    (stat),
        .inverse (inverse),
        .status  (status)
    );

endmodule
